[rtl/lr_pkg.sv]
`timescale 1ns / 1ps

package lr_pkg;

    localparam int MAX_DIM  = 64;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;
    localparam int COLOUR_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COLOR_RED    = 3'd2,
        CFG_COLOR_GREEN  = 3'd3,
        CFG_COLOR_BLUE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic last;
    } t_stat;

endpackage

[rtl/lr_ctrl.sv]
`timescale 1ns / 1ps

module lr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lr_pkg::t_stat i_stat,
    output lr_pkg::t_cmd  o_cmd
);

    lr_pkg::t_state r_state;
    lr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lr_pkg::ST_SETUP;
                end
            end
            lr_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = lr_pkg::ST_DRAW;
            end
            lr_pkg::ST_DRAW: begin
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last) begin
                        n_state = lr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lr_datapath.sv]
`timescale 1ns / 1ps

module lr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lr_pkg::t_cmd                        i_cmd,
    output lr_pkg::t_stat                       o_stat,
    input  logic                                i_cfg_valid,
    input  logic [lr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [lr_pkg::COORD_W-1:0]          i_start_x,
    input  logic [lr_pkg::COORD_W-1:0]          i_start_y,
    input  logic [lr_pkg::COORD_W-1:0]          i_end_x,
    input  logic [lr_pkg::COORD_W-1:0]          i_end_y,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [lr_pkg::COORD_W-1:0]          o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0]          o_pixel_y,
    output logic [lr_pkg::COLOUR_W-1:0]         o_pixel_red,
    output logic [lr_pkg::COLOUR_W-1:0]         o_pixel_green,
    output logic [lr_pkg::COLOUR_W-1:0]         o_pixel_blue,
    output logic                                o_last_pixel,
    output logic                                o_range_error
);

    localparam logic [lr_pkg::DIM_W-1:0] MaxDim = lr_pkg::DIM_W'(lr_pkg::MAX_DIM);

    // configuration registers
    logic [lr_pkg::DIM_W-1:0]    r_width;
    logic [lr_pkg::DIM_W-1:0]    r_height;
    logic [lr_pkg::COLOUR_W-1:0] r_red;
    logic [lr_pkg::COLOUR_W-1:0] r_green;
    logic [lr_pkg::COLOUR_W-1:0] r_blue;

    // latched endpoints
    logic [lr_pkg::COORD_W-1:0]  r_x1, r_y1, r_x2, r_y2;

    // stepping state
    logic [lr_pkg::COORD_W-1:0]  r_cx, r_cy;
    logic [lr_pkg::COORD_W-1:0]  r_major, r_minor;
    logic [lr_pkg::DIM_W-1:0]    r_acc;
    logic [lr_pkg::DIM_W-1:0]    r_cnt;
    logic                        r_x_major, r_xinc, r_yinc, r_err;

    // output register
    logic                        r_out_valid;
    logic [lr_pkg::COORD_W-1:0]  r_px, r_py;
    logic [lr_pkg::COLOUR_W-1:0] r_pr, r_pg, r_pb;
    logic                        r_plast, r_perr;

    logic                        range_err;
    logic                        xlt, ylt;
    logic [lr_pkg::COORD_W-1:0]  dx, dy;
    logic [lr_pkg::DIM_W-1:0]    acc_sum;
    logic                        ovf;
    logic [lr_pkg::COORD_W-1:0]  x_step, y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MaxDim;
            r_height <= MaxDim;
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lr_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[lr_pkg::DIM_W-1:0];
                lr_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[lr_pkg::DIM_W-1:0];
                lr_pkg::CFG_COLOR_RED:    r_red    <= i_cfg_data;
                lr_pkg::CFG_COLOR_GREEN:  r_green  <= i_cfg_data;
                lr_pkg::CFG_COLOR_BLUE:   r_blue   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        range_err = ({1'b0, r_x1} >= r_width)  || ({1'b0, r_x2} >= r_width)
                 || ({1'b0, r_x1} >= MaxDim)   || ({1'b0, r_x2} >= MaxDim)
                 || ({1'b0, r_y1} >= r_height) || ({1'b0, r_y2} >= r_height)
                 || ({1'b0, r_y1} >= MaxDim)   || ({1'b0, r_y2} >= MaxDim);
        xlt = r_x1 < r_x2;
        ylt = r_y1 < r_y2;
        dx  = xlt ? r_x2 - r_x1 : r_x1 - r_x2;
        dy  = ylt ? r_y2 - r_y1 : r_y1 - r_y2;

        acc_sum = r_acc + {1'b0, r_minor};
        ovf     = acc_sum >= {1'b0, r_major};
        x_step  = r_xinc ? r_cx + 1'b1 : r_cx - 1'b1;
        y_step  = r_yinc ? r_cy + 1'b1 : r_cy - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1 <= i_start_x;
            r_y1 <= i_start_y;
            r_x2 <= i_end_x;
            r_y2 <= i_end_y;
        end
        if (i_cmd.setup) begin
            r_err <= range_err;
            r_acc <= '0;
            if (range_err) begin
                r_cnt <= lr_pkg::DIM_W'(1);
            end else if (r_x1 == r_x2) begin
                // vertical: walk rows upwards from the smaller one
                r_x_major <= 1'b0;
                r_yinc    <= 1'b1;
                r_xinc    <= 1'b1;
                r_major   <= dy;
                r_minor   <= '0;
                r_cx      <= r_x1;
                r_cy      <= ylt ? r_y1 : r_y2;
                r_cnt     <= {1'b0, dy} + 1'b1;
            end else if (r_y1 == r_y2) begin
                r_x_major <= 1'b1;
                r_xinc    <= 1'b1;
                r_yinc    <= 1'b1;
                r_major   <= dx;
                r_minor   <= '0;
                r_cx      <= xlt ? r_x1 : r_x2;
                r_cy      <= r_y1;
                r_cnt     <= {1'b0, dx} + 1'b1;
            end else begin
                // end point excluded: major span steps
                r_x_major <= dx >= dy;
                r_xinc    <= xlt;
                r_yinc    <= ylt;
                r_major   <= (dx >= dy) ? dx : dy;
                r_minor   <= (dx >= dy) ? dy : dx;
                r_cx      <= r_x1;
                r_cy      <= r_y1;
                r_cnt     <= {1'b0, (dx >= dy) ? dx : dy};
            end
        end
        if (i_cmd.step) begin
            r_cnt <= r_cnt - 1'b1;
            r_acc <= ovf ? acc_sum - {1'b0, r_major} : acc_sum;
            if (r_x_major) begin
                r_cx <= x_step;
                if (ovf) begin
                    r_cy <= y_step;
                end
            end else begin
                r_cy <= y_step;
                if (ovf) begin
                    r_cx <= x_step;
                end
            end
            r_px    <= r_err ? '0 : r_cx;
            r_py    <= r_err ? '0 : r_cy;
            r_pr    <= r_err ? '0 : r_red;
            r_pg    <= r_err ? '0 : r_green;
            r_pb    <= r_err ? '0 : r_blue;
            r_plast <= r_cnt == lr_pkg::DIM_W'(1);
            r_perr  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.last     = r_cnt == lr_pkg::DIM_W'(1);

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_red   = r_pr;
    assign o_pixel_green = r_pg;
    assign o_pixel_blue  = r_pb;
    assign o_last_pixel  = r_plast;
    assign o_range_error = r_perr;

endmodule

[rtl/line_rasterizer.sv]
`timescale 1ns / 1ps

// Line rasteriser: each input item carries two endpoints and produces a run
// of pixel items in the configured colour, one per cycle while the output is
// not stalled, the final one flagged by last_pixel. A command with an
// endpoint outside the configured image gives a single item with
// range_error and last_pixel set and all other fields zero. An item is
// latched on acceptance, set up in the setup state, then drawn pixel by
// pixel (up to 64) in the single stepping unit; the next item is accepted
// the cycle after the last pixel enters the output register. Configuration
// writes are always accepted and must only be issued while the block is idle.
module line_rasterizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lr_pkg::COORD_W-1:0]          i_start_x,
    input  logic [lr_pkg::COORD_W-1:0]          i_start_y,
    input  logic [lr_pkg::COORD_W-1:0]          i_end_x,
    input  logic [lr_pkg::COORD_W-1:0]          i_end_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lr_pkg::COORD_W-1:0]          o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0]          o_pixel_y,
    output logic [lr_pkg::COLOUR_W-1:0]         o_pixel_red,
    output logic [lr_pkg::COLOUR_W-1:0]         o_pixel_green,
    output logic [lr_pkg::COLOUR_W-1:0]         o_pixel_blue,
    output logic                                o_last_pixel,
    output logic                                o_range_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    lr_pkg::t_cmd  cmd;
    lr_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    lr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_red   (o_pixel_red),
        .o_pixel_green (o_pixel_green),
        .o_pixel_blue  (o_pixel_blue),
        .o_last_pixel  (o_last_pixel),
        .o_range_error (o_range_error)
    );

endmodule
